FILE: design/stick_to_button_duty_modulator_unit_assert.svh
// Assertion macros shared by the duty modulator RTL.
`ifndef STICK_TO_BUTTON_DUTY_MODULATOR_UNIT_ASSERT_SVH
`define STICK_TO_BUTTON_DUTY_MODULATOR_UNIT_ASSERT_SVH
`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define SBDM_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("sbdm assertion failed");
// Condition must never be seen outside reset.
`define SBDM_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("sbdm forbidden condition seen");
`else
`define SBDM_ASSERT(lbl, clk, rst, prop)
`define SBDM_ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

FILE: design/sbdm_pkg.sv
// Types and constants of the stick-to-button duty modulator.
`timescale 1ns / 1ps

package sbdm_pkg;

   // Stick geometry.
   localparam logic [7:0] AXIS_CENTRE = 8'd128;
   localparam logic [7:0] FULL_SCALE  = 8'd127;

   // Field widths.
   localparam int BUTTON_W = 32;
   localparam int TIME_W   = 32;
   localparam int MASK_W   = 24;
   localparam int BAND_W   = 7;
   localparam int WINDOW_W = 11;
   localparam int PROD_W   = 18;

   // Pipeline shape: one prep stage, the modulo stages, a multiply stage and the output.
   localparam int MOD_STEPS  = 4;
   localparam int MOD_STAGES = TIME_W / MOD_STEPS;
   localparam int MUL_STAGE  = MOD_STAGES + 1;
   localparam int OUT_STAGE  = MOD_STAGES + 2;
   localparam int NUM_STAGES = MOD_STAGES + 3;

   // Register indexes on the configuration port.
   typedef enum logic [2:0] {
      CSR_RX_POS_MASK = 3'd0,
      CSR_RX_NEG_MASK = 3'd1,
      CSR_RY_POS_MASK = 3'd2,
      CSR_RY_NEG_MASK = 3'd3,
      CSR_OUTER_BAND  = 3'd4,
      CSR_INNER_BAND  = 3'd5,
      CSR_DUTY_WINDOW = 3'd6
   } csr_index_type;

   // Register reset values.
   localparam logic [MASK_W-1:0]   RST_RX_POS_MASK = 24'h000000;
   localparam logic [MASK_W-1:0]   RST_RX_NEG_MASK = 24'h000000;
   localparam logic [MASK_W-1:0]   RST_RY_POS_MASK = 24'h008000;
   localparam logic [MASK_W-1:0]   RST_RY_NEG_MASK = 24'h004000;
   localparam logic [BAND_W-1:0]   RST_OUTER_BAND  = 7'd20;
   localparam logic [BAND_W-1:0]   RST_INNER_BAND  = 7'd10;
   localparam logic [WINDOW_W-1:0] RST_DUTY_WINDOW = 11'd16;

   // Prepared half-axis of one stick axis.
   typedef struct packed {
      logic              on;
      logic              neg;
      logic [BAND_W-1:0] lvl;
   } axis_type;

   // Contents of one pipeline stage.
   typedef struct packed {
      logic [BUTTON_W-1:0] word;
      logic                last;
      logic                inv;
      logic [TIME_W-1:0]   tim;
      logic [WINDOW_W-1:0] rem;
      axis_type            x_axis;
      axis_type            y_axis;
      logic [PROD_W-1:0]   x_prod;
      logic [PROD_W-1:0]   y_prod;
      logic [PROD_W-1:0]   thr;
   } pipe_type;

endpackage

FILE: design/stick_to_button_duty_modulator_unit.sv
// Top level of the stick-to-button duty modulator: config registers and sample pipeline.
// Throughput: one word per cycle while no stage stalls; the eleven stages are the prep stage,
// the eight-stage timestamp modulo chain (four remainder steps per stage), one multiply stage
// and the output.
// Each stage stalls only when it is full and the stage after it cannot take its word.
// Reset is synchronous, active high: it empties the pipeline and loads register defaults.
`timescale 1ns / 1ps
`include "stick_to_button_duty_modulator_unit_assert.svh"

module stick_to_button_duty_modulator_unit
   import sbdm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Sample channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,  // buttons_in[31:0], stick_x[39:32], stick_y[47:40],
                                   // sample_time[79:48]
   input  logic        req_tuser,  // active_low
   input  logic        req_tlast,  // last_sample
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // buttons_out[31:0]
   output logic        rsp_tlast,  // last_out
   // Configuration write channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_data
);

   // Configuration registers.
   logic [MASK_W-1:0]   rx_pos_mask_ff;
   logic [MASK_W-1:0]   rx_neg_mask_ff;
   logic [MASK_W-1:0]   ry_pos_mask_ff;
   logic [MASK_W-1:0]   ry_neg_mask_ff;
   logic [BAND_W-1:0]   outer_band_ff;
   logic [BAND_W-1:0]   inner_band_ff;
   logic [WINDOW_W-1:0] duty_window_ff;

   // Values derived from the configuration.
   logic [7:0]          band_sum;
   logic                span_ok;
   logic [BAND_W-1:0]   span;
   logic [WINDOW_W-1:0] w_eff;
   logic [WINDOW_W-1:0] w_m1;

   // Pipeline.
   pipe_type stg_ff [NUM_STAGES];
   pipe_type stg_in [NUM_STAGES];
   logic     vld_ff [NUM_STAGES];
   logic     vld_in [NUM_STAGES];
   logic     rdy    [NUM_STAGES+1];

   // Deflection, dead band and clamp for one axis.
   function automatic axis_type prep_axis(logic [7:0] pos, logic [BAND_W-1:0] inner,
                                          logic [BAND_W-1:0] spn, logic spn_ok);
      axis_type   a;
      logic [7:0] defl;
      logic [7:0] lvl8;
      a    = '0;
      defl = '0;
      if (pos > AXIS_CENTRE) begin
         defl = pos - AXIS_CENTRE;
      end else if (pos < AXIS_CENTRE) begin
         defl = AXIS_CENTRE - pos;
         if (defl > FULL_SCALE) begin
            defl = FULL_SCALE;
         end
      end
      a.neg = (pos < AXIS_CENTRE);
      a.on  = spn_ok && (pos != AXIS_CENTRE) && (defl >= {1'b0, inner});
      lvl8  = defl - {1'b0, inner};
      a.lvl = (lvl8 > {1'b0, spn}) ? spn : lvl8[BAND_W-1:0];
      return a;
   endfunction

   // Register writes; an index beyond the list is dropped.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_pos_mask_ff <= RST_RX_POS_MASK;
         rx_neg_mask_ff <= RST_RX_NEG_MASK;
         ry_pos_mask_ff <= RST_RY_POS_MASK;
         ry_neg_mask_ff <= RST_RY_NEG_MASK;
         outer_band_ff  <= RST_OUTER_BAND;
         inner_band_ff  <= RST_INNER_BAND;
         duty_window_ff <= RST_DUTY_WINDOW;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_RX_POS_MASK: rx_pos_mask_ff <= csr_data;
            CSR_RX_NEG_MASK: rx_neg_mask_ff <= csr_data;
            CSR_RY_POS_MASK: ry_pos_mask_ff <= csr_data;
            CSR_RY_NEG_MASK: ry_neg_mask_ff <= csr_data;
            CSR_OUTER_BAND:  outer_band_ff  <= csr_data[BAND_W-1:0];
            CSR_INNER_BAND:  inner_band_ff  <= csr_data[BAND_W-1:0];
            CSR_DUTY_WINDOW: duty_window_ff <= csr_data[WINDOW_W-1:0];
            default: ;
         endcase
      end
   end

   // Span between the two dead bands and the effective window.
   always_comb begin
      band_sum = {1'b0, outer_band_ff} + {1'b0, inner_band_ff};
      span_ok  = (band_sum < FULL_SCALE);
      span     = BAND_W'(FULL_SCALE - band_sum);
      w_eff    = (duty_window_ff == '0) ? WINDOW_W'(1) : duty_window_ff;
      w_m1     = w_eff - WINDOW_W'(1);
   end

   // Stage contents. The duty test slice >= phase is evaluated as
   // level * (w - 1) >= (t mod w) * span, which needs no division.
   always_comb begin
      logic [WINDOW_W:0] tmp;
      logic [MASK_W-1:0] mask;
      tmp  = '0;
      mask = '0;

      // Prep stage: polarity, deflections and levels.
      stg_in[0]        = '0;
      stg_in[0].word   = req_tuser ? ~req_tdata[31:0] : req_tdata[31:0];
      stg_in[0].last   = req_tlast;
      stg_in[0].inv    = req_tuser;
      stg_in[0].tim    = req_tdata[79:48];
      stg_in[0].x_axis = prep_axis(req_tdata[39:32], inner_band_ff, span, span_ok);
      stg_in[0].y_axis = prep_axis(req_tdata[47:40], inner_band_ff, span, span_ok);

      // Modulo stages: restoring remainder, four timestamp bits per stage.
      for (int i = 1; i <= MOD_STAGES; i++) begin
         stg_in[i] = stg_ff[i-1];
         for (int j = 0; j < MOD_STEPS; j++) begin
            tmp = {stg_in[i].rem, stg_in[i].tim[TIME_W-1]};
            stg_in[i].tim = {stg_in[i].tim[TIME_W-2:0], 1'b0};
            if (tmp >= {1'b0, w_eff}) begin
               tmp = tmp - {1'b0, w_eff};
            end
            stg_in[i].rem = tmp[WINDOW_W-1:0];
         end
      end

      // Multiply stage.
      stg_in[MUL_STAGE]        = stg_ff[MUL_STAGE-1];
      stg_in[MUL_STAGE].x_prod = PROD_W'(stg_ff[MUL_STAGE-1].x_axis.lvl) * PROD_W'(w_m1);
      stg_in[MUL_STAGE].y_prod = PROD_W'(stg_ff[MUL_STAGE-1].y_axis.lvl) * PROD_W'(w_m1);
      stg_in[MUL_STAGE].thr    = PROD_W'(stg_ff[MUL_STAGE-1].rem) * PROD_W'(span);

      // Output stage: compare, merge the masks and restore polarity.
      stg_in[OUT_STAGE] = stg_ff[OUT_STAGE-1];
      if (stg_ff[OUT_STAGE-1].x_axis.on &&
          (stg_ff[OUT_STAGE-1].x_prod >= stg_ff[OUT_STAGE-1].thr)) begin
         mask = stg_ff[OUT_STAGE-1].x_axis.neg ? rx_neg_mask_ff : rx_pos_mask_ff;
         stg_in[OUT_STAGE].word = stg_in[OUT_STAGE].word | {8'd0, mask};
      end
      if (stg_ff[OUT_STAGE-1].y_axis.on &&
          (stg_ff[OUT_STAGE-1].y_prod >= stg_ff[OUT_STAGE-1].thr)) begin
         mask = stg_ff[OUT_STAGE-1].y_axis.neg ? ry_neg_mask_ff : ry_pos_mask_ff;
         stg_in[OUT_STAGE].word = stg_in[OUT_STAGE].word | {8'd0, mask};
      end
      if (stg_ff[OUT_STAGE-1].inv) begin
         stg_in[OUT_STAGE].word = ~stg_in[OUT_STAGE].word;
      end
   end

   // Per-stage flow control: a stage takes a new word when it is empty or its word moves on.
   always_comb begin
      rdy[NUM_STAGES] = rsp_tready;
      for (int i = NUM_STAGES - 1; i >= 0; i--) begin
         rdy[i] = !vld_ff[i] || rdy[i+1];
      end
      vld_in[0] = req_tvalid;
      for (int i = 1; i < NUM_STAGES; i++) begin
         vld_in[i] = vld_ff[i-1];
      end
   end

   assign req_tready = rdy[0];

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_STAGES; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else begin
         for (int i = 0; i < NUM_STAGES; i++) begin
            if (rdy[i]) begin
               vld_ff[i] <= vld_in[i];
            end
         end
      end
   end

   // Stage payload.
   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_STAGES; i++) begin
         if (rdy[i]) begin
            stg_ff[i] <= stg_in[i];
         end
      end
   end

   // Result word.
   assign rsp_tvalid = vld_ff[OUT_STAGE];
   assign rsp_tdata  = stg_ff[OUT_STAGE].word;
   assign rsp_tlast  = stg_ff[OUT_STAGE].last;

   // An accepted word always lands in the prep stage.
   `SBDM_ASSERT(a_accept_fills_prep, clock, reset, (req_tvalid && req_tready) |=> vld_ff[0])
   // A blocked prep stage keeps its word unchanged.
   `SBDM_ASSERT(a_prep_holds, clock, reset,
      (vld_ff[0] && !rdy[1]) |=> (vld_ff[0] && $stable(stg_ff[0])))
   // With no half-axis active, the word passes through with its polarity restored.
   `SBDM_ASSERT(a_idle_axes_pass, clock, reset,
      (vld_ff[MUL_STAGE] && rdy[OUT_STAGE] && !stg_ff[MUL_STAGE].x_axis.on &&
       !stg_ff[MUL_STAGE].y_axis.on) |=>
      (rsp_tdata == ($past(stg_ff[MUL_STAGE].inv) ? ~$past(stg_ff[MUL_STAGE].word) :
                     $past(stg_ff[MUL_STAGE].word))))
   // An empty output register means nothing can block the input.
   `SBDM_ASSERT_NEVER(a_no_false_stall, clock, reset, !rsp_tvalid && !req_tready)

endmodule

FILE: tb/sv/stick_to_button_duty_modulator_unit_test.sv
// Self-checking testbench of the stick-to-button duty modulator with a word scoreboard.
`timescale 1ns / 1ps

module stick_to_button_duty_modulator_unit_test
   import sbdm_pkg::*;
();

   localparam int QUIET_LIMIT   = 2000;
   localparam int DRAIN_CYCLES  = 24;
   localparam int PHASE_ITEMS   = 115;
   localparam int REPORT_LIMIT  = 10;
   // Index beyond the register file; writes to it must change nothing.
   localparam logic [2:0] CSR_UNUSED_INDEX = 3'd7;

   // One controller sample as it travels on the request channel.
   typedef struct {
      logic [31:0] buttons;
      logic [7:0]  stick_x;
      logic [7:0]  stick_y;
      logic [31:0] stamp;
      logic        active_low;
      logic        last;
   } pad_sample_type;

   // One merged button word as it should leave the block.
   typedef struct {
      logic [31:0] buttons;
      logic        last;
   } merged_word_type;

   // Keeps a copy of the registers, predicts each merged word and checks the results.
   class duty_scoreboard;
      logic [MASK_W-1:0]   rx_pos_mask;
      logic [MASK_W-1:0]   rx_neg_mask;
      logic [MASK_W-1:0]   ry_pos_mask;
      logic [MASK_W-1:0]   ry_neg_mask;
      logic [BAND_W-1:0]   outer_band;
      logic [BAND_W-1:0]   inner_band;
      logic [WINDOW_W-1:0] window;
      merged_word_type     expected_words[$];
      int                  errors;
      int                  samples;
      int                  results;

      function new();
         rx_pos_mask = RST_RX_POS_MASK;
         rx_neg_mask = RST_RX_NEG_MASK;
         ry_pos_mask = RST_RY_POS_MASK;
         ry_neg_mask = RST_RY_NEG_MASK;
         outer_band  = RST_OUTER_BAND;
         inner_band  = RST_INNER_BAND;
         window      = RST_DUTY_WINDOW;
         errors      = 0;
         samples     = 0;
         results     = 0;
      endfunction

      // Register writes are cut to each register's width; unknown indexes are dropped.
      function void write_reg(logic [2:0] idx, logic [23:0] data);
         case (idx)
            CSR_RX_POS_MASK: rx_pos_mask = data;
            CSR_RX_NEG_MASK: rx_neg_mask = data;
            CSR_RY_POS_MASK: ry_pos_mask = data;
            CSR_RY_NEG_MASK: ry_neg_mask = data;
            CSR_OUTER_BAND:  outer_band  = data[BAND_W-1:0];
            CSR_INNER_BAND:  inner_band  = data[BAND_W-1:0];
            CSR_DUTY_WINDOW: window      = data[WINDOW_W-1:0];
            default: ;
         endcase
      endfunction

      // A half-axis presses while its duty slice reaches the phase of the timestamp.
      function bit half_axis_presses(int unsigned defl, int unsigned stamp);
         int unsigned band_sum;
         int unsigned win;
         int unsigned span;
         int unsigned level;
         int unsigned slice;
         int unsigned phase;
         band_sum = outer_band + inner_band;
         win      = (window == 0) ? 1 : window;
         if (band_sum >= FULL_SCALE) return 1'b0;
         span = FULL_SCALE - band_sum;
         if (defl < inner_band) return 1'b0;
         level = defl - inner_band;
         if (level > span) level = span;
         slice = 1 + (level * (win - 1)) / span;
         phase = stamp % win + 1;
         return slice >= phase;
      endfunction

      // Buttons that one stick axis adds; the centre value drives neither side.
      function logic [MASK_W-1:0] axis_buttons(logic [7:0] pos, logic [MASK_W-1:0] pos_mask,
                                               logic [MASK_W-1:0] neg_mask, int unsigned stamp);
         int unsigned defl;
         if (pos > AXIS_CENTRE) begin
            defl = pos - AXIS_CENTRE;
            return half_axis_presses(defl, stamp) ? pos_mask : '0;
         end
         if (pos < AXIS_CENTRE) begin
            defl = AXIS_CENTRE - pos;
            if (defl > FULL_SCALE) defl = FULL_SCALE;
            return half_axis_presses(defl, stamp) ? neg_mask : '0;
         end
         return '0;
      endfunction

      function void note_sample(pad_sample_type s);
         merged_word_type m;
         logic [31:0]     w;
         w = s.active_low ? ~s.buttons : s.buttons;
         w |= {8'h00, axis_buttons(s.stick_x, rx_pos_mask, rx_neg_mask, s.stamp)};
         w |= {8'h00, axis_buttons(s.stick_y, ry_pos_mask, ry_neg_mask, s.stamp)};
         m.buttons = s.active_low ? ~w : w;
         m.last    = s.last;
         expected_words.push_back(m);
         samples++;
      endfunction

      function void report(string what, logic [31:0] exp_val, logic [31:0] got_val);
         errors++;
         if (errors <= REPORT_LIMIT)
            $display("mismatch on %s at %0t: expected %h, got %h", what, $time, exp_val, got_val);
      endfunction

      function void check_result(logic [31:0] buttons, logic last);
         merged_word_type m;
         results++;
         if (expected_words.size() == 0) begin
            report("word with nothing outstanding", 32'h0, buttons);
            return;
         end
         m = expected_words.pop_front();
         if (buttons !== m.buttons) report("buttons_out", m.buttons, buttons);
         if (last !== m.last) report("last_out", {31'h0, m.last}, {31'h0, last});
      endfunction

      function int pending();
         return expected_words.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;  // buttons_in, stick_x, stick_y, sample_time
   logic        req_tuser = 1'b0; // active_low
   logic        req_tlast = 1'b0; // last_sample
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;       // buttons_out
   logic        rsp_tlast;       // last_out
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [23:0] csr_data = '0;

   duty_scoreboard sb;
   bit             sender_gaps = 1'b1;
   bit             receiver_stalls = 1'b1;
   int             stall_left = 0;
   int             quiet_cycles = 0;
   int             settings_applied = 0;

   stick_to_button_duty_modulator_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic pad_sample_type make_sample(logic [31:0] buttons, logic [7:0] sx,
                                                  logic [7:0] sy, logic [31:0] stamp,
                                                  logic active_low, logic last);
      pad_sample_type s;
      s.buttons    = buttons;
      s.stick_x    = sx;
      s.stick_y    = sy;
      s.stamp      = stamp;
      s.active_low = active_low;
      s.last       = last;
      return s;
   endfunction

   // The receiver stalls in random bursts while stalls are enabled.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else if (receiver_stalls && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         stall_left = $urandom_range(0, 2);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Every handshake is observed here; the watchdog ends a run that stops moving.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.write_reg(csr_index, csr_data);
         if (req_tvalid && req_tready)
            sb.note_sample(make_sample(req_tdata[31:0], req_tdata[39:32], req_tdata[47:40],
                                       req_tdata[79:48], req_tuser, req_tlast));
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tlast);
         if ((csr_valid && csr_ready) || (req_tvalid && req_tready) ||
             (rsp_tvalid && rsp_tready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
               $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
               $display("** stick_to_button_duty_modulator_unit: FAILED **");
               $finish;
            end
         end
      end
   end

   // Offers one sample, possibly after a short gap; returns at the falling edge after acceptance.
   task automatic send_sample(pad_sample_type s);
      if (sender_gaps && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {s.stamp, s.stick_y, s.stick_x, s.buttons};
      req_tuser  <= s.active_low;
      req_tlast  <= s.last;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Writes one register; the caller lowers csr_valid after its last write.
   task automatic write_csr(logic [2:0] idx, logic [23:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   // Loads a full register setting once the pipeline has delivered every word.
   task automatic apply_setting(logic [23:0] rxp, logic [23:0] rxn, logic [23:0] ryp,
                                logic [23:0] ryn, logic [6:0] outer, logic [6:0] inner,
                                logic [10:0] win);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      write_csr(CSR_RX_POS_MASK, rxp);
      write_csr(CSR_RX_NEG_MASK, rxn);
      write_csr(CSR_RY_POS_MASK, ryp);
      write_csr(CSR_RY_NEG_MASK, ryn);
      // Bits above a register's width carry noise that must be dropped.
      write_csr(CSR_OUTER_BAND, {17'($urandom), outer});
      write_csr(CSR_INNER_BAND, {17'($urandom), inner});
      write_csr(CSR_DUTY_WINDOW, {13'($urandom), win});
      write_csr(CSR_UNUSED_INDEX, 24'($urandom));
      csr_valid <= 1'b0;
      settings_applied++;
   endtask

   function automatic logic [7:0] pick_axis();
      case ($urandom_range(0, 7))
         0: return AXIS_CENTRE;
         1: return 8'd0;
         2: return 8'd255;
         3: return 8'($urandom_range(100, 156));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_random(int count);
      pad_sample_type s;
      for (int i = 0; i < count; i++) begin
         s.buttons    = $urandom;
         s.stick_x    = pick_axis();
         s.stick_y    = pick_axis();
         s.stamp      = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 3000)) : $urandom;
         s.active_low = 1'($urandom_range(0, 1));
         s.last       = ($urandom_range(0, 7) == 0);
         send_sample(s);
      end
   endtask

   initial begin
      sb = new();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed samples against the register defaults.
      send_sample(make_sample(32'h0, 8'd128, 8'd128, 32'd0, 1'b0, 1'b0));
      send_sample(make_sample(32'h0, 8'd128, 8'd255, 32'd0, 1'b0, 1'b0));
      send_sample(make_sample(32'hFFFFFFFF, 8'd128, 8'd0, 32'd15, 1'b1, 1'b1));
      send_sample(make_sample(32'h12345678, 8'd128, 8'd133, 32'd3, 1'b0, 1'b0));
      send_sample(make_sample(32'h0, 8'd128, 8'd138, 32'd0, 1'b0, 1'b1));
      send_sample(make_sample(32'h0, 8'd128, 8'd138, 32'd1, 1'b0, 1'b0));

      // Directed samples with a distinct mask per half-axis.
      apply_setting(24'h000011, 24'h000220, 24'h004400, 24'h880000, 7'd17, 7'd10, 11'd100);
      send_sample(make_sample(32'h0, 8'd255, 8'd0, 32'hFFFFFFFF, 1'b0, 1'b0));
      send_sample(make_sample(32'h0, 8'd0, 8'd255, 32'd99, 1'b0, 1'b0));
      send_sample(make_sample(32'h0, 8'd1, 8'd254, 32'd50, 1'b0, 1'b0));
      send_sample(make_sample(32'h0, 8'd127, 8'd129, 32'd0, 1'b0, 1'b0));
      send_sample(make_sample(32'h0, 8'd118, 8'd138, 32'd0, 1'b0, 1'b0));
      send_sample(make_sample(32'h0, 8'd117, 8'd139, 32'd1, 1'b0, 1'b0));
      send_sample(make_sample(32'hFFFFFFFF, 8'd128, 8'd128, 32'd7, 1'b0, 1'b1));
      send_sample(make_sample(32'hFFFFFFFF, 8'd128, 8'd128, 32'd7, 1'b1, 1'b0));
      send_sample(make_sample(32'h0, 8'd255, 8'd255, 32'd5, 1'b1, 1'b0));
      send_sample(make_sample(32'hA5A5A5A5, 8'd0, 8'd0, 32'd12345, 1'b1, 1'b1));
      send_sample(make_sample(32'h0, 8'd200, 8'd60, 32'h80000000, 1'b0, 1'b0));
      send_sample(make_sample(32'h0, 8'd60, 8'd200, 32'h7FFFFFFF, 1'b0, 1'b0));
      send_sample(make_sample(32'h0, 8'd129, 8'd127, 32'd0, 1'b0, 1'b0));
      send_sample(make_sample(32'h5A5A5A5A, 8'd255, 8'd128, 32'd0, 1'b0, 1'b1));

      // Random samples over a range of settings, extremes first.
      apply_setting(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                    7'd0, 7'd0, 11'd1);
      send_random(PHASE_ITEMS);
      // Band sum far above full scale: the span is negative, nothing is pressed.
      apply_setting(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 7'd127, 7'd127, 11'd16);
      send_random(PHASE_ITEMS);
      apply_setting(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                    7'd0, 7'd126, 11'd1024);
      send_random(PHASE_ITEMS);
      apply_setting(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                    7'd126, 7'd0, 11'd7);
      send_random(PHASE_ITEMS);
      // Band sum exactly at full scale.
      apply_setting(24'h0, 24'h0, 24'h0, 24'h0, 7'd63, 7'd64, 11'd300);
      send_random(PHASE_ITEMS);
      // A zero window behaves as a window of one.
      apply_setting(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                    7'd5, 7'd5, 11'd0);
      send_random(PHASE_ITEMS);
      apply_setting(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 7'd0, 7'd0, 11'd2047);
      send_random(PHASE_ITEMS);
      apply_setting(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                    7'($urandom_range(0, 30)), 7'($urandom_range(0, 30)), 11'd1025);
      send_random(PHASE_ITEMS);
      repeat (3) begin
         apply_setting(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                       7'($urandom_range(0, 40)), 7'($urandom_range(0, 40)),
                       11'($urandom_range(1, 1024)));
         send_random(PHASE_ITEMS);
      end
      // Closing stretch at full rate on both sides.
      apply_setting(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                    7'($urandom_range(0, 40)), 7'($urandom_range(0, 40)),
                    11'($urandom_range(1, 64)));
      sender_gaps     = 1'b0;
      receiver_stalls = 1'b0;
      send_random(PHASE_ITEMS);
      req_tvalid <= 1'b0;

      while (sb.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Sent %0d samples and checked %0d merged words under %0d register settings.",
               sb.samples, sb.results, settings_applied);
      $display("%s", {"Settings spanned zero, unit and oversized windows, ",
                      "empty spans and both polarities."});
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("** stick_to_button_duty_modulator_unit: PASSED **");
      end else begin
         $display("%0d mismatches, %0d words still outstanding", sb.errors, sb.pending());
         $display("** stick_to_button_duty_modulator_unit: FAILED **");
      end
      $finish;
   end

endmodule
